[sv/sat_pkg.sv]
// shared types and constants for the segment address translator
package sat_pkg;

    localparam int ADDR_W = 64;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [5:0] SPACE_BITS_RESET       = 6'd36;
    localparam logic [3:0] ACTIVE_SEGS_RESET      = 4'd1;
    localparam logic       TRANSLATE_ENABLE_RESET = 1'b0;
    localparam logic [5:0] MIN_LOAD_WIDTH         = 6'd2;

    // register indexes, byte address is four times the index
    localparam logic [1:0] REG_SPACE_BITS       = 2'd0;
    localparam logic [1:0] REG_ACTIVE_SEGS      = 2'd1;
    localparam logic [1:0] REG_TRANSLATE_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_REV   = 2'd2,
        MODE_CHECK = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_CHECK_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        logic [5:0] space_bits;
        logic [3:0] active_segs;
        logic       translate_enable;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] offset;
        logic              invalid;
    } seg_entry_t;

    localparam seg_entry_t SEG_RESET = '{start: '0, offset: '0, invalid: 1'b1};

endpackage

[sv/sat_req_if.sv]
// request channel: one segment load, translation or table check per beat
interface sat_req_if
    import sat_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [3:0]        seg_index;
    logic [ADDR_W-1:0] seg_start;
    logic [ADDR_W-1:0] seg_offset_raw;
    logic              seg_invalid;
    logic [ADDR_W-1:0] address_in;

    modport source (
        output valid, mode, seg_index, seg_start, seg_offset_raw, seg_invalid, address_in,
        input  ready
    );

    modport sink (
        input  valid, mode, seg_index, seg_start, seg_offset_raw, seg_invalid, address_in,
        output ready
    );
endinterface

[sv/sat_rsp_if.sv]
// response channel: translated address and status per beat
interface sat_rsp_if
    import sat_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] translated_addr;
    logic [1:0]        status;

    modport source (
        output valid, translated_addr, status,
        input  ready
    );

    modport sink (
        input  valid, translated_addr, status,
        output ready
    );
endinterface

[sv/sat_apb.sv]
// apb configuration registers
module sat_apb
    import sat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_strobe;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.space_bits       <= SPACE_BITS_RESET;
            cfg_reg.active_segs      <= ACTIVE_SEGS_RESET;
            cfg_reg.translate_enable <= TRANSLATE_ENABLE_RESET;
        end
        else if (wr_strobe)
        begin
            unique case (paddr[3:2])
                REG_SPACE_BITS:       cfg_reg.space_bits       <= pwdata[5:0];
                REG_ACTIVE_SEGS:      cfg_reg.active_segs      <= pwdata[3:0];
                REG_TRANSLATE_ENABLE: cfg_reg.translate_enable <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SPACE_BITS:       prdata = {{(APB_DW-6){1'b0}}, cfg_reg.space_bits};
            REG_ACTIVE_SEGS:      prdata = {{(APB_DW-4){1'b0}}, cfg_reg.active_segs};
            REG_TRANSLATE_ENABLE: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.translate_enable};
            default:              prdata = '0;
        endcase
    end

endmodule

[sv/sat_alu.sv]
// shared 64-bit adder / subtractor with unsigned less-than flag
module sat_alu
    import sat_pkg::*;
(
    input  logic [ADDR_W-1:0] x,
    input  logic [ADDR_W-1:0] y,
    input  logic              sub,
    output logic [ADDR_W-1:0] sum,
    output logic              lt
);

    logic [ADDR_W:0] full;

    assign full = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{ADDR_W{1'b0}}, sub};
    assign sum  = full[ADDR_W-1:0];
    // no carry out of x + ~y + 1 means x < y
    assign lt   = sub & ~full[ADDR_W];

endmodule

[sv/sat_store.sv]
// segment table memory with written bits and sentinel read-out
module sat_store
    import sat_pkg::*;
#(
    parameter  int SEGMENTS = 10,
    localparam int IDX_W    = $clog2(SEGMENTS + 1),
    localparam int MEM_AW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [MEM_AW-1:0] wr_idx,
    input  seg_entry_t        wr_entry,
    input  logic [IDX_W-1:0]  rd_a_addr,
    input  logic [IDX_W-1:0]  rd_b_addr,
    input  logic [IDX_W-1:0]  used,
    input  logic [ADDR_W-1:0] top_addr,
    output seg_entry_t        rd_a,
    output seg_entry_t        rd_b
);

    seg_entry_t          mem [SEGMENTS];
    logic [SEGMENTS-1:0] written_reg;
    seg_entry_t          a_data_reg;
    seg_entry_t          b_data_reg;
    logic                a_hit_reg;
    logic                b_hit_reg;
    logic                a_written_reg;
    logic                b_written_reg;
    seg_entry_t          sentinel;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        a_data_reg    <= mem[rd_a_addr[MEM_AW-1:0]];
        b_data_reg    <= mem[rd_b_addr[MEM_AW-1:0]];
        a_written_reg <= written_reg[rd_a_addr[MEM_AW-1:0]];
        b_written_reg <= written_reg[rd_b_addr[MEM_AW-1:0]];
        a_hit_reg     <= rd_a_addr < used;
        b_hit_reg     <= rd_b_addr < used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_idx] <= 1'b1;
        end
    end

    // entries past the used count read as the top-of-space marker
    assign sentinel = '{start: top_addr, offset: '0, invalid: 1'b1};

    assign rd_a = a_hit_reg ? (a_written_reg ? a_data_reg : SEG_RESET) : sentinel;
    assign rd_b = b_hit_reg ? (b_written_reg ? b_data_reg : SEG_RESET) : sentinel;

endmodule

[sv/segment_address_translator.sv]
// top level: segment table address translator with a shared adder under a sequencer
//
//  channel  | dir | beat content                                         | handshake
//  ---------+-----+------------------------------------------------------+-------------
//  req      | in  | mode, seg_index, seg_start, seg_offset_raw,          | valid/ready
//           |     | seg_invalid, address_in                              |
//  rsp      | out | translated_addr, status                              | valid/ready
//  apb      | in  | space_bits, active_segs, translate_enable            | psel/penable
//
//  one request at a time: a load goes from accept through S_LOAD and S_DONE to the response
//  register, a forward translation makes one compare per segment, a reverse translation
//  and a table check scan the used segments and, for the check, every pair of them;
//  all of it is paced by the single 64-bit adder and the table's two read ports
//  reset clears the written bits of the table at once, so no clearing sweep follows
//  a new request is taken while a finished response still waits in the output register;
//  the sequencer then holds its result until the output register frees up
module segment_address_translator
    import sat_pkg::*;
#(
    parameter int SEGMENTS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    sat_req_if.sink           req,
    sat_rsp_if.source         rsp
);

    localparam int IDX_W  = $clog2(SEGMENTS + 1);
    localparam int MEM_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0] SEG_COUNT = IDX_W'(SEGMENTS);

    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_LOAD     = 19'b0000000000000000010,
        S_FWD      = 19'b0000000000000000100,
        S_FWD_ADD  = 19'b0000000000000001000,
        S_REV_LO   = 19'b0000000000000010000,
        S_REV_HI   = 19'b0000000000000100000,
        S_REV_CLO  = 19'b0000000000001000000,
        S_REV_CHI  = 19'b0000000000010000000,
        S_REV_SUB  = 19'b0000000000100000000,
        S_CHK_MONO = 19'b0000000001000000000,
        S_CHK_I    = 19'b0000000010000000000,
        S_CHK_IE   = 19'b0000000100000000000,
        S_CHK_J    = 19'b0000001000000000000,
        S_CHK_JE   = 19'b0000010000000000000,
        S_CHK_C1   = 19'b0000100000000000000,
        S_CHK_C2   = 19'b0001000000000000000,
        S_CHK_C3   = 19'b0010000000000000000,
        S_CHK_C4   = 19'b0100000000000000000,
        S_DONE     = 19'b1000000000000000000
    } state_t;

    // configuration
    cfg_t              cfg;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] off_sign;
    logic [IDX_W-1:0]  used_count;
    logic              count_bad;

    // sequencer state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic              le_reg, le_next;
    logic              seen_reg, seen_next;
    logic              cmp_reg, cmp_next;
    logic              sep_reg, sep_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0] blo_reg, blo_next;
    logic [ADDR_W-1:0] bhi_reg, bhi_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    status_t           status_reg, status_next;

    // captured request beat
    logic [3:0]        idx_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] raw_reg;
    logic              inv_reg;
    logic [ADDR_W-1:0] addr_reg;

    // output register
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    status_t           out_status_reg;
    logic              out_load;

    // shared adder and table
    logic [ADDR_W-1:0] alu_x, alu_y, alu_sum;
    logic              alu_sub, alu_lt;
    logic              wr_en;
    seg_entry_t        wr_entry;
    seg_entry_t        rd_a, rd_b;

    logic              accept;
    logic [IDX_W-1:0]  last_idx;
    logic              cur_last;
    logic [IDX_W-1:0]  cur_inc;
    logic [IDX_W-1:0]  i_inc;
    logic              i_done;

    sat_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sat_alu u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .sub (alu_sub),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    // read ports are addressed with the next index, so the registered data
    // always belongs to cur_reg (port a) and cur_reg + 1 (port b)
    sat_store #(
        .SEGMENTS (SEGMENTS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_idx    (idx_reg[MEM_AW-1:0]),
        .wr_entry  (wr_entry),
        .rd_a_addr (cur_next),
        .rd_b_addr (cur_next + IDX_ONE),
        .used      (n_next),
        .top_addr  (top_addr),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    // top of the address space and the offset sign bit
    assign top_addr = ADDR_W'(1) << cfg.space_bits;
    assign off_sign = ADDR_W'(1) << (cfg.space_bits - 6'd1);

    always_comb
    begin
        if (int'(cfg.active_segs) > SEGMENTS)
        begin
            used_count = SEG_COUNT;
        end
        else
        begin
            used_count = IDX_W'(cfg.active_segs);
        end
    end

    assign count_bad = (cfg.active_segs == 4'd0) || (int'(cfg.active_segs) > SEGMENTS);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign last_idx = n_reg - IDX_ONE;
    assign cur_last = (cur_reg == last_idx);
    assign cur_inc  = cur_reg + IDX_ONE;
    assign i_inc    = i_reg + IDX_ONE;
    // outer check index runs up to the second-last segment
    assign i_done   = (i_inc == last_idx);

    // segment zero always starts at address zero
    assign wr_entry = '{start:   (idx_reg == 4'd0) ? '0 : start_reg,
                        offset:  alu_sum,
                        invalid: inv_reg};

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        le_next     = le_reg;
        seen_next   = seen_reg;
        cmp_next    = cmp_reg;
        sep_next    = sep_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        blo_next    = blo_reg;
        bhi_next    = bhi_reg;
        res_next    = res_reg;
        status_next = status_reg;
        alu_x       = '0;
        alu_y       = '0;
        alu_sub     = 1'b0;
        wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next      = used_count;
                    cur_next    = '0;
                    i_next      = '0;
                    res_next    = '0;
                    status_next = ST_OK;
                    // segment zero starts at zero, so it always lies at or below the address
                    le_next     = 1'b1;
                    seen_next   = 1'b0;
                    unique case (mode_t'(req.mode))
                        MODE_LOAD:
                        begin
                            state_next = S_LOAD;
                        end
                        MODE_FWD:
                        begin
                            if (!cfg.translate_enable)
                            begin
                                res_next   = req.address_in;
                                state_next = S_DONE;
                            end
                            else if (used_count == '0)
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FWD;
                            end
                        end
                        MODE_REV:
                        begin
                            if (used_count == '0)
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_REV_LO;
                            end
                        end
                        MODE_CHECK:
                        begin
                            if (count_bad)
                            begin
                                status_next = ST_CHECK_FAIL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CHK_MONO;
                            end
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                // sign extension: (raw ^ s) - s
                alu_x      = raw_reg ^ off_sign;
                alu_y      = off_sign;
                alu_sub    = 1'b1;
                wr_en      = (cfg.space_bits >= MIN_LOAD_WIDTH) && (int'(idx_reg) < SEGMENTS);
                state_next = S_DONE;
            end

            S_FWD:
            begin
                // address below the next start, and le_reg says at or above this start
                alu_x   = addr_reg;
                alu_y   = rd_b.start;
                alu_sub = 1'b1;
                if (le_reg && alu_lt)
                begin
                    if (rd_a.invalid)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FWD_ADD;
                    end
                end
                else if (cur_last)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    le_next  = !alu_lt;
                    cur_next = cur_inc;
                end
            end

            S_FWD_ADD:
            begin
                alu_x      = addr_reg;
                alu_y      = rd_a.offset;
                res_next   = alu_sum;
                state_next = S_DONE;
            end

            S_REV_LO:
            begin
                alu_x = rd_a.start;
                alu_y = rd_a.offset;
                if (rd_a.invalid)
                begin
                    if (cur_last)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cur_next = cur_inc;
                    end
                end
                else
                begin
                    lo_next    = alu_sum;
                    state_next = S_REV_HI;
                end
            end

            S_REV_HI:
            begin
                alu_x      = rd_b.start;
                alu_y      = rd_a.offset;
                hi_next    = alu_sum;
                state_next = S_REV_CLO;
            end

            S_REV_CLO:
            begin
                alu_x   = addr_reg;
                alu_y   = lo_reg;
                alu_sub = 1'b1;
                if (!alu_lt)
                begin
                    state_next = S_REV_CHI;
                end
                else if (cur_last)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = cur_inc;
                    state_next = S_REV_LO;
                end
            end

            S_REV_CHI:
            begin
                alu_x   = addr_reg;
                alu_y   = hi_reg;
                alu_sub = 1'b1;
                if (alu_lt)
                begin
                    state_next = S_REV_SUB;
                end
                else if (cur_last)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = cur_inc;
                    state_next = S_REV_LO;
                end
            end

            S_REV_SUB:
            begin
                alu_x       = addr_reg;
                alu_y       = rd_a.offset;
                alu_sub     = 1'b1;
                res_next    = alu_sum;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_CHK_MONO:
            begin
                // start order; the last segment only counts once a valid one came before
                alu_x   = rd_a.start;
                alu_y   = rd_b.start;
                alu_sub = 1'b1;
                if (!rd_a.invalid && !alu_lt && (!cur_last || seen_reg))
                begin
                    status_next = ST_CHECK_FAIL;
                    state_next  = S_DONE;
                end
                else if (cur_last)
                begin
                    if (n_reg == IDX_ONE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next   = '0;
                        i_next     = '0;
                        state_next = S_CHK_I;
                    end
                end
                else
                begin
                    seen_next = seen_reg | !rd_a.invalid;
                    cur_next  = cur_inc;
                end
            end

            S_CHK_I:
            begin
                alu_x = rd_a.start;
                alu_y = rd_a.offset;
                if (rd_a.invalid)
                begin
                    if (i_done)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next   = i_inc;
                        cur_next = i_inc;
                    end
                end
                else
                begin
                    blo_next   = alu_sum;
                    state_next = S_CHK_IE;
                end
            end

            S_CHK_IE:
            begin
                alu_x      = rd_b.start;
                alu_y      = rd_a.offset;
                bhi_next   = alu_sum;
                cur_next   = i_inc;
                state_next = S_CHK_J;
            end

            S_CHK_J:
            begin
                alu_x = rd_a.start;
                alu_y = rd_a.offset;
                if (rd_a.invalid)
                begin
                    if (!cur_last)
                    begin
                        cur_next = cur_inc;
                    end
                    else if (i_done)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        cur_next   = i_inc;
                        state_next = S_CHK_I;
                    end
                end
                else
                begin
                    lo_next    = alu_sum;
                    state_next = S_CHK_JE;
                end
            end

            S_CHK_JE:
            begin
                alu_x      = rd_b.start;
                alu_y      = rd_a.offset;
                hi_next    = alu_sum;
                state_next = S_CHK_C1;
            end

            S_CHK_C1:
            begin
                // outer base below inner base
                alu_x      = blo_reg;
                alu_y      = lo_reg;
                alu_sub    = 1'b1;
                cmp_next   = alu_lt;
                state_next = S_CHK_C2;
            end

            S_CHK_C2:
            begin
                // outer end at or below inner base
                alu_x      = lo_reg;
                alu_y      = bhi_reg;
                alu_sub    = 1'b1;
                sep_next   = cmp_reg && !alu_lt;
                state_next = S_CHK_C3;
            end

            S_CHK_C3:
            begin
                // inner base below outer base
                alu_x      = lo_reg;
                alu_y      = blo_reg;
                alu_sub    = 1'b1;
                cmp_next   = alu_lt;
                state_next = S_CHK_C4;
            end

            S_CHK_C4:
            begin
                // inner end at or below outer base
                alu_x   = blo_reg;
                alu_y   = hi_reg;
                alu_sub = 1'b1;
                if (!(sep_reg || (cmp_reg && !alu_lt)))
                begin
                    status_next = ST_CHECK_FAIL;
                    state_next  = S_DONE;
                end
                else if (!cur_last)
                begin
                    cur_next   = cur_inc;
                    state_next = S_CHK_J;
                end
                else if (i_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_inc;
                    cur_next   = i_inc;
                    state_next = S_CHK_I;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            i_reg     <= '0;
            n_reg     <= '0;
            le_reg    <= 1'b0;
            seen_reg  <= 1'b0;
            cmp_reg   <= 1'b0;
            sep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            le_reg    <= le_next;
            seen_reg  <= seen_next;
            cmp_reg   <= cmp_next;
            sep_reg   <= sep_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        blo_reg    <= blo_next;
        bhi_reg    <= bhi_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        if (accept)
        begin
            idx_reg   <= req.seg_index;
            start_reg <= req.seg_start;
            raw_reg   <= req.seg_offset_raw;
            inv_reg   <= req.seg_invalid;
            addr_reg  <= req.address_in;
        end
    end

    // response register: filled from the finished result, drained by the sink
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_addr_reg   <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.translated_addr = out_addr_reg;
    assign rsp.status          = out_status_reg;

    // an accepted request always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request did not start the sequencer");

    // scanning never reads past the used segments
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD || state_reg == S_REV_LO || state_reg == S_CHK_MONO)
            |-> (cur_reg < n_reg))
        else $error("segment scan index beyond used count");

    // inner check index stays above the outer one
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_J) |-> (i_reg < cur_reg))
        else $error("table check pair out of order");

    // a failed beat carries a zero address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.translated_addr == '0))
        else $error("non-zero address on failed response");

endmodule
